// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
// Bodies refer to clk and rst_n of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ROVG_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define ROVG_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rovg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the radial outline vertex generator.
// No dependencies; used by every RTL module of the block.
package rovg_pkg;

    // Field and register widths
    localparam int RADIUS_W   = 16;
    localparam int PCOUNT_W   = 9;
    localparam int PHASE_W    = 16;
    localparam int IRAD_W     = 16;
    localparam int COORD_W    = 20;
    localparam int VNUM_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Parameter defaults
    localparam int DEF_INTERP_FACTOR = 4;
    localparam int DEF_MAX_POINTS    = 256;
    localparam int MIN_POINTS        = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ITEM_RADIUS = 2'd2;

    // Configuration reset values
    localparam logic [PCOUNT_W-1:0] PCOUNT_RST = 9'd3;
    localparam logic [PHASE_W-1:0]  PSTEP_RST  = 16'd5461;
    localparam logic [IRAD_W-1:0]   IRAD_RST   = 16'd16;

    // Quarter-wave polynomial coefficients, Q14
    localparam logic [15:0] SIN_A    = 16'd25736;
    localparam logic [15:0] SIN_B    = 16'd10512;
    localparam logic [15:0] SIN_C    = 16'd1160;
    localparam logic [15:0] Q14_ONE  = 16'd16384;

    // Shared multiplier geometry
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Output saturation limits
    localparam logic signed [COORD_W-1:0] COORD_MAX = 20'sh7FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 20'sh80000;

    // Per-vertex micro-steps of the shared multiplier
    typedef enum logic [3:0] {
        U_DIV = 4'd0,   // sub-radius numerator times reciprocal
        U_RQ  = 4'd1,   // correct quotient, sine x*x
        U_SX2 = 4'd2,   // sine C*x2
        U_SB  = 4'd3,   // sine (B - .)*x2
        U_SA  = 4'd4,   // sine (A - .)*x
        U_CXX = 4'd5,   // store sine, cosine x*x
        U_CX2 = 4'd6,   // cosine C*x2
        U_CB  = 4'd7,   // cosine (B - .)*x2
        U_CA  = 4'd8,   // cosine (A - .)*x
        U_RS  = 4'd9,   // store cosine, r*sin
        U_RC  = 4'd10,  // store x weight, r*cos
        U_IX  = 4'd11,  // store y weight, radius*x weight
        U_IY  = 4'd12,  // store x, radius*y weight
        U_VY  = 4'd13   // load output register
    } step_t;

    // Controller to datapath commands
    typedef struct packed {
        logic  first_load;
        logic  capture;
        logic  seg_load;
        logic  closing;
        logic  step_en;
        step_t step;
        logic  emit;
        logic  last_vertex;
        logic  finish;
        logic  finish_last;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic count_ok;
        logic is_first;
        logic is_last;
        logic out_free;
    } stat_t;

    // Round a Q14 product half up back to Q14
    function automatic logic [15:0] q14_round(input logic signed [MUL_P_W-1:0] p);
        logic [MUL_P_W-1:0] t;
        t = MUL_P_W'(p) + MUL_P_W'(8192);
        return t[29:14];
    endfunction

    // Fold a turn fraction onto the rising quarter-wave, Q0.14 (0..16384)
    function automatic logic [14:0] fold_x(input logic [PHASE_W-1:0] p);
        logic [14:0] frac;
        frac = {1'b0, p[13:0]};
        return p[14] ? (Q14_ONE[14:0] - frac) : frac;
    endfunction

    // Clamp a quarter-wave value and apply the half-turn sign
    function automatic logic signed [15:0] sine_sign(input logic [15:0] v,
                                                     input logic neg);
        logic [15:0] s;
        s = (v > Q14_ONE) ? Q14_ONE : v;
        return neg ? -$signed(s) : $signed(s);
    endfunction

    // Scale down by 2^28 rounding half up, then saturate to the coordinate range
    function automatic logic signed [COORD_W-1:0] coord_sat(
        input logic signed [MUL_P_W-1:0] p);
        logic signed [MUL_P_W-1:0] v;
        logic signed [MUL_P_W-29:0] q;
        v = p + (MUL_P_W'(1) << 27);
        q = v[MUL_P_W-1:28];
        if (q > (MUL_P_W-28)'(COORD_MAX))
            return COORD_MAX;
        else if (q < (MUL_P_W-28)'(COORD_MIN))
            return COORD_MIN;
        else
            return q[COORD_W-1:0];
    endfunction

endpackage

// ===== rtl/radial_outline_vertex_gen.sv =====
// Each radius that ends a segment is computed as INTERP_FACTOR vertices; the closing radius also
// computes the segment back to the first radius. Each vertex takes 13 shared multiplier steps and
// one output load. The first radius of an outline and ignored radii only update state, and the
// input stays open. A vertex waiting at the output holds the next vertex load and the input.
// Reset (rst_n, asynchronous, low) restores register defaults and clears outline state.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module radial_outline_vertex_gen #(
    parameter int INTERP_FACTOR = rovg_pkg::DEF_INTERP_FACTOR,
    parameter int MAX_POINTS    = rovg_pkg::DEF_MAX_POINTS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rovg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rovg_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [rovg_pkg::RADIUS_W-1:0]        radius,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [rovg_pkg::COORD_W-1:0]  vertex_x,
    output logic signed [rovg_pkg::COORD_W-1:0]  vertex_y,
    output logic [rovg_pkg::VNUM_W-1:0]          vertex_number,
    output logic                                 outline_done
);
    import rovg_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  in_drop;

    // Sequencer
    rovg_ctrl #(
        .INTERP_FACTOR (INTERP_FACTOR)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Arithmetic and state
    rovg_datapath #(
        .INTERP_FACTOR (INTERP_FACTOR),
        .MAX_POINTS    (MAX_POINTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .radius        (radius),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .vertex_x      (vertex_x),
        .vertex_y      (vertex_y),
        .vertex_number (vertex_number),
        .outline_done  (outline_done),
        .cmd           (cmd),
        .stat          (stat)
    );

    // Radius taken while the count is too short
    assign in_drop = in_valid && in_ready && !stat.count_ok;

    // Never load a vertex over one still waiting at the output
    `ROVG_ASSERT_IMP(a_emit_slot_free, cmd.emit, stat.out_free, "vertex loaded into busy output")
    // Starting a segment keeps the input closed
    `ROVG_ASSERT_NXT(a_seg_busy, cmd.seg_load, !in_ready, "input open during segment")
    // A radius dropped for a short count leaves the block idle
    `ROVG_ASSERT_NXT(a_drop_idle, in_drop, in_ready, "dropped item left block busy")
    // A loaded vertex is offered next cycle
    `ROVG_ASSERT_NXT(a_emit_valid, cmd.emit, out_valid, "loaded vertex not offered")

endmodule

// ===== rtl/rovg_mult.sv =====
`timescale 1ns / 1ps
// Shared signed multiplier with registered product.
// Depends on rovg_pkg for operand widths.
module rovg_mult (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [rovg_pkg::MUL_A_W-1:0]  a,
    input  logic signed [rovg_pkg::MUL_B_W-1:0]  b,
    output logic signed [rovg_pkg::MUL_P_W-1:0]  prod
);
    import rovg_pkg::*;

    logic signed [MUL_P_W-1:0] prod_reg;

    // Capture the product when a step runs, hold otherwise
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/rovg_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: configuration registers, outline state, interpolation, sine/cosine
// polynomial and coordinate scaling around one shared multiplier, output register.
// Depends on rovg_pkg and rovg_mult.
module rovg_datapath #(
    parameter int INTERP_FACTOR = rovg_pkg::DEF_INTERP_FACTOR,
    parameter int MAX_POINTS    = rovg_pkg::DEF_MAX_POINTS
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [rovg_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [rovg_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  logic [rovg_pkg::RADIUS_W-1:0]            radius,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output logic signed [rovg_pkg::COORD_W-1:0]      vertex_x,
    output logic signed [rovg_pkg::COORD_W-1:0]      vertex_y,
    output logic [rovg_pkg::VNUM_W-1:0]              vertex_number,
    output logic                                     outline_done,
    input  rovg_pkg::cmd_t                           cmd,
    output rovg_pkg::stat_t                          stat
);
    import rovg_pkg::*;

    localparam int NUM_W = RADIUS_W + $clog2(INTERP_FACTOR);
    localparam int DIV_K = NUM_W;
    localparam logic [MUL_B_W-1:0] RECIP = MUL_B_W'((64'd1 << DIV_K) / INTERP_FACTOR);
    localparam int CMP_W = (PCOUNT_W + 1 > $clog2(MAX_POINTS + 1)) ?
                           PCOUNT_W + 1 : $clog2(MAX_POINTS + 1);

    // Configuration
    logic [PCOUNT_W-1:0] point_count_reg;
    logic [PHASE_W-1:0]  phase_step_reg;
    logic [IRAD_W-1:0]   item_radius_reg;

    // Outline state
    logic [RADIUS_W-1:0] first_radius_reg;
    logic [RADIUS_W-1:0] prev_radius_reg;
    logic [PCOUNT_W-1:0] point_index_reg;
    logic [PHASE_W-1:0]  phase_reg;
    logic [VNUM_W-1:0]   vcnt_reg;

    // Working registers
    logic [RADIUS_W-1:0]        cur_radius_reg;
    logic [NUM_W-1:0]           num_reg;
    logic signed [RADIUS_W:0]   delta_reg;
    logic [RADIUS_W-1:0]        sub_r_reg;
    logic [15:0]                x2_reg;
    logic signed [15:0]         sin_reg;
    logic signed [15:0]         cos_reg;
    logic signed [MUL_A_W-1:0]  wx_reg;
    logic signed [MUL_A_W-1:0]  wy_reg;
    logic signed [COORD_W-1:0]  vx_reg;

    // Output register
    logic                       out_valid_reg;
    logic signed [COORD_W-1:0]  out_x_reg;
    logic signed [COORD_W-1:0]  out_y_reg;
    logic [VNUM_W-1:0]          out_num_reg;
    logic                       out_done_reg;

    // Combinational helpers
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_P_W-1:0]  prod;
    logic [15:0]                rnd;
    logic [PHASE_W-1:0]         phase_c;
    logic [14:0]                xs;
    logic [14:0]                xc;
    logic [RADIUS_W-1:0]        seg_a;
    logic [RADIUS_W-1:0]        seg_b;
    logic [RADIUS_W-1:0]        q0;
    logic [NUM_W-1:0]           rem;
    logic [RADIUS_W-1:0]        quot;
    logic signed [NUM_W:0]      num_sum;
    logic [CMP_W-1:0]           cnt_eff;

    assign cfg_ready = 1'b1;

    // Effective point count and outline status
    always_comb
    begin
        if (CMP_W'(point_count_reg) > CMP_W'(MAX_POINTS))
            cnt_eff = CMP_W'(MAX_POINTS);
        else
            cnt_eff = CMP_W'(point_count_reg);
        stat.count_ok = cnt_eff >= CMP_W'(MIN_POINTS);
        stat.is_first = point_index_reg == '0;
        stat.is_last  = (CMP_W'(point_index_reg) + CMP_W'(1)) >= cnt_eff;
        stat.out_free = !out_valid_reg || out_ready;
    end

    // Segment end points
    assign seg_a = cmd.closing ? cur_radius_reg : prev_radius_reg;
    assign seg_b = cmd.closing ? first_radius_reg : cur_radius_reg;

    // Quotient of the sub-radius numerator, one correction step
    assign q0   = prod[DIV_K+RADIUS_W-1:DIV_K];
    assign rem  = num_reg - NUM_W'(32'(q0) * INTERP_FACTOR);
    assign quot = (rem >= NUM_W'(INTERP_FACTOR)) ? q0 + 1'b1 : q0;

    assign num_sum = $signed({1'b0, num_reg}) + (NUM_W+1)'(delta_reg);

    // Polynomial operands
    assign rnd     = q14_round(prod);
    assign phase_c = phase_reg + Q14_ONE;
    assign xs      = fold_x(phase_reg);
    assign xc      = fold_x(phase_c);

    // Select multiplier operands for the current step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.step)
            U_DIV:
            begin
                mul_a = MUL_A_W'(num_reg);
                mul_b = RECIP;
            end
            U_RQ:
            begin
                mul_a = MUL_A_W'(xs);
                mul_b = MUL_B_W'(xs);
            end
            U_SX2, U_CX2:
            begin
                mul_a = MUL_A_W'(SIN_C);
                mul_b = MUL_B_W'(rnd);
            end
            U_SB, U_CB:
            begin
                mul_a = MUL_A_W'(SIN_B - rnd);
                mul_b = MUL_B_W'(x2_reg);
            end
            U_SA:
            begin
                mul_a = MUL_A_W'(SIN_A - rnd);
                mul_b = MUL_B_W'(xs);
            end
            U_CXX:
            begin
                mul_a = MUL_A_W'(xc);
                mul_b = MUL_B_W'(xc);
            end
            U_CA:
            begin
                mul_a = MUL_A_W'(SIN_A - rnd);
                mul_b = MUL_B_W'(xc);
            end
            U_RS:
            begin
                mul_a = MUL_A_W'(sin_reg);
                mul_b = MUL_B_W'(sub_r_reg);
            end
            U_RC:
            begin
                mul_a = MUL_A_W'(cos_reg);
                mul_b = MUL_B_W'(sub_r_reg);
            end
            U_IX:
            begin
                mul_a = wx_reg;
                mul_b = MUL_B_W'(item_radius_reg);
            end
            U_IY:
            begin
                mul_a = wy_reg;
                mul_b = MUL_B_W'(item_radius_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    rovg_mult u_mult (
        .clk  (clk),
        .en   (cmd.step_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= PCOUNT_RST;
            phase_step_reg  <= PSTEP_RST;
            item_radius_reg <= IRAD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_POINT_COUNT: point_count_reg <= cfg_data[PCOUNT_W-1:0];
                CFG_PHASE_STEP:  phase_step_reg  <= cfg_data[PHASE_W-1:0];
                CFG_ITEM_RADIUS: item_radius_reg <= cfg_data[IRAD_W-1:0];
                default:         point_count_reg <= point_count_reg;
            endcase
        end
    end

    // Outline state: start, per-vertex advance, end of item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_radius_reg <= '0;
            prev_radius_reg  <= '0;
            point_index_reg  <= '0;
            phase_reg        <= '0;
            vcnt_reg         <= '0;
        end
        else
        begin
            if (cmd.first_load)
            begin
                first_radius_reg <= radius;
                prev_radius_reg  <= radius;
                point_index_reg  <= PCOUNT_W'(1);
                phase_reg        <= '0;
                vcnt_reg         <= '0;
            end
            if (cmd.emit)
            begin
                phase_reg <= phase_reg + phase_step_reg;
                vcnt_reg  <= vcnt_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                prev_radius_reg <= cur_radius_reg;
                point_index_reg <= cmd.finish_last ? '0 : point_index_reg + 1'b1;
            end
        end
    end

    // Working registers of the vertex computation
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cur_radius_reg <= radius;
        end
        if (cmd.seg_load)
        begin
            num_reg   <= NUM_W'(32'(seg_a) * INTERP_FACTOR + INTERP_FACTOR / 2);
            delta_reg <= $signed({1'b0, seg_b}) - $signed({1'b0, seg_a});
        end
        if (cmd.emit)
        begin
            num_reg <= num_sum[NUM_W-1:0];
        end
        if (cmd.step_en)
        begin
            case (cmd.step)
                U_RQ:          sub_r_reg <= quot;
                U_SX2, U_CX2:  x2_reg    <= rnd;
                U_CXX:         sin_reg   <= sine_sign(rnd, phase_reg[PHASE_W-1]);
                U_RS:          cos_reg   <= sine_sign(rnd, phase_c[PHASE_W-1]);
                U_RC:          wx_reg    <= MUL_A_W'(prod + (MUL_P_W'(1) << 28));
                U_IX:          wy_reg    <= MUL_A_W'(prod + (MUL_P_W'(1) << 28));
                U_IY:          vx_reg    <= coord_sat(prod);
                default:       vx_reg    <= vx_reg;
            endcase
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_x_reg    <= vx_reg;
            out_y_reg    <= coord_sat(prod);
            out_num_reg  <= vcnt_reg;
            out_done_reg <= cmd.last_vertex;
        end
    end

    assign out_valid     = out_valid_reg;
    assign vertex_x      = out_x_reg;
    assign vertex_y      = out_y_reg;
    assign vertex_number = out_num_reg;
    assign outline_done  = out_done_reg;

endmodule

// ===== rtl/rovg_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: accepts radii, walks segments, sub-steps and multiplier micro-steps.
// Depends on rovg_pkg for the command, status and step types.
module rovg_ctrl #(
    parameter int INTERP_FACTOR = rovg_pkg::DEF_INTERP_FACTOR
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  rovg_pkg::stat_t  stat,
    output rovg_pkg::cmd_t   cmd
);
    import rovg_pkg::*;

    localparam int SUB_W = (INTERP_FACTOR > 1) ? $clog2(INTERP_FACTOR) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SEG  = 3'b010,
        ST_CALC = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    step_t            step_reg, step_next;
    logic [SUB_W-1:0] sub_reg, sub_next;
    logic             closing_reg, closing_next;
    logic             last_reg, last_next;
    logic             last_sub;
    logic             accept;

    assign in_ready = state_reg == ST_IDLE;
    assign accept   = in_valid && in_ready;
    assign last_sub = sub_reg == SUB_W'(INTERP_FACTOR - 1);

    // Sequence items, segments and micro-steps
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        sub_next     = sub_reg;
        closing_next = closing_reg;
        last_next    = last_reg;
        cmd          = '0;
        cmd.step     = step_reg;
        cmd.closing  = closing_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && stat.count_ok)
                begin
                    if (stat.is_first)
                    begin
                        cmd.first_load = 1'b1;
                    end
                    else
                    begin
                        cmd.capture  = 1'b1;
                        last_next    = stat.is_last;
                        closing_next = 1'b0;
                        state_next   = ST_SEG;
                    end
                end
            end
            ST_SEG:
            begin
                cmd.seg_load = 1'b1;
                sub_next     = '0;
                step_next    = U_DIV;
                state_next   = ST_CALC;
            end
            ST_CALC:
            begin
                if (step_reg != U_VY)
                begin
                    cmd.step_en = 1'b1;
                    case (step_reg)
                        U_DIV:   step_next = U_RQ;
                        U_RQ:    step_next = U_SX2;
                        U_SX2:   step_next = U_SB;
                        U_SB:    step_next = U_SA;
                        U_SA:    step_next = U_CXX;
                        U_CXX:   step_next = U_CX2;
                        U_CX2:   step_next = U_CB;
                        U_CB:    step_next = U_CA;
                        U_CA:    step_next = U_RS;
                        U_RS:    step_next = U_RC;
                        U_RC:    step_next = U_IX;
                        U_IX:    step_next = U_IY;
                        U_IY:    step_next = U_VY;
                        default: step_next = U_DIV;
                    endcase
                end
                else if (stat.out_free)
                begin
                    // Hand the vertex to the output register
                    cmd.step_en     = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.last_vertex = closing_reg && last_sub;
                    step_next       = U_DIV;
                    if (!last_sub)
                    begin
                        sub_next = sub_reg + 1'b1;
                    end
                    else if (last_reg && !closing_reg)
                    begin
                        closing_next = 1'b1;
                        state_next   = ST_SEG;
                    end
                    else
                    begin
                        cmd.finish      = 1'b1;
                        cmd.finish_last = last_reg;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            step_reg    <= U_DIV;
            sub_reg     <= '0;
            closing_reg <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            sub_reg     <= sub_next;
            closing_reg <= closing_next;
            last_reg    <= last_next;
        end
    end

endmodule

// ===== test/radial_outline_vertex_gen_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for radial_outline_vertex_gen: streams radius items and register
// writes, predicts every vertex of each outline and checks the vertex stream field by field.
// Depends on rovg_pkg and the radial_outline_vertex_gen RTL.
module radial_outline_vertex_gen_tb;
    import rovg_pkg::*;

    localparam int SUBSTEPS      = DEF_INTERP_FACTOR;
    localparam int POINT_CAP     = DEF_MAX_POINTS;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 5000;
    localparam int CHOKE_AT      = 150;
    localparam int CHOKE_CYCLES  = 800;
    localparam int RANDOM_RADII  = 260;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [VNUM_W-1:0]         num;
        logic                      done;
    } vertex_t;

    logic                         clk           = 1'b0;
    logic                         rst_n         = 1'b0;
    logic                         cfg_valid     = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index     = '0;
    logic [CFG_DATA_W-1:0]        cfg_data      = '0;
    logic                         in_valid      = 1'b0;
    logic                         in_ready;
    logic [RADIUS_W-1:0]          radius        = '0;
    logic                         out_valid;
    logic                         out_ready     = 1'b0;
    logic signed [COORD_W-1:0]    vertex_x;
    logic signed [COORD_W-1:0]    vertex_y;
    logic [VNUM_W-1:0]            vertex_number;
    logic                         outline_done;

    // Register copies and outline state of the predictor
    logic [PCOUNT_W-1:0]          cfg_points    = PCOUNT_RST;
    logic [PHASE_W-1:0]           cfg_step      = PSTEP_RST;
    logic [IRAD_W-1:0]            cfg_irad      = IRAD_RST;
    logic [RADIUS_W-1:0]          st_first      = '0;
    logic [RADIUS_W-1:0]          st_prev       = '0;
    logic [PCOUNT_W-1:0]          st_index      = '0;
    logic [PHASE_W-1:0]           st_phase      = '0;

    logic [RADIUS_W-1:0]          radius_feed[$];
    vertex_t                      expected_vertices[$];
    vertex_t                      want_vertex;
    int                           radii_queued  = 0;
    int                           radii_taken   = 0;
    int                           vertices_seen = 0;
    int                           mismatch_count = 0;
    int                           feed_gap      = 0;
    int                           sink_hold     = 0;
    bit                           choke_done    = 1'b0;
    int                           tick          = 0;
    int                           idle_cycles   = 0;

    radial_outline_vertex_gen uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .radius        (radius),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .vertex_x      (vertex_x),
        .vertex_y      (vertex_y),
        .vertex_number (vertex_number),
        .outline_done  (outline_done)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Q14 product rounded half up
    function automatic int unsigned q14_product(int unsigned a, int unsigned b);
        return (a * b + 32'd8192) >> 14;
    endfunction

    // Rising quarter of the sine polynomial, input Q0.14
    function automatic int unsigned quarter_wave(int unsigned x);
        int unsigned x2;
        int unsigned t;
        x2 = q14_product(x, x);
        t = 32'(SIN_B) - q14_product(32'(SIN_C), x2);
        t = 32'(SIN_A) - q14_product(t, x2);
        t = q14_product(t, x);
        return (t > 32'd16384) ? 32'd16384 : t;
    endfunction

    // Signed Q1.14 sine of a turn fraction
    function automatic int wave_q14(logic [PHASE_W-1:0] ph);
        int unsigned mag;
        mag = ph[14] ? quarter_wave(32'd16384 - 32'(ph[13:0])) : quarter_wave(32'(ph[13:0]));
        return ph[15] ? -int'(mag) : int'(mag);
    endfunction

    // item_radius * (1 + r*s), scaled to signed Q20.0, floor of x + 1/2, saturated
    function automatic logic signed [COORD_W-1:0] pixel_coord(int unsigned r, int s);
        longint acc;
        acc = longint'(cfg_irad) * (longint'(1) << 28)
            + longint'(cfg_irad) * (longint'(r) * longint'(s))
            + (longint'(1) << 27);
        acc = acc >>> 28;
        if (acc > longint'(COORD_MAX))
            acc = longint'(COORD_MAX);
        else if (acc < longint'(COORD_MIN))
            acc = longint'(COORD_MIN);
        return COORD_W'(acc);
    endfunction

    // Interpolate one segment and queue its vertices, advancing the phase per vertex
    function automatic void trace_segment(logic [RADIUS_W-1:0] a, logic [RADIUS_W-1:0] b,
                                          int seg, bit closing);
        vertex_t     v;
        int unsigned r;
        for (int j = 0; j < SUBSTEPS; j++)
        begin
            r = (32'(SUBSTEPS - j) * 32'(a) + 32'(j) * 32'(b) + 32'(SUBSTEPS / 2))
                / 32'(SUBSTEPS);
            v.x    = pixel_coord(r, wave_q14(st_phase));
            v.y    = pixel_coord(r, wave_q14(PHASE_W'(st_phase + 16'd16384)));
            v.num  = VNUM_W'(seg * SUBSTEPS + j);
            v.done = closing && (j == SUBSTEPS - 1);
            expected_vertices.push_back(v);
            st_phase = st_phase + cfg_step;
        end
    endfunction

    // Apply one accepted radius to the outline state
    function automatic void outline_advance(logic [RADIUS_W-1:0] r);
        int cnt;
        cnt = (cfg_points > POINT_CAP) ? POINT_CAP : int'(cfg_points);
        if (cnt < MIN_POINTS)
            return;
        if (st_index == 0)
        begin
            st_first = r;
            st_prev  = r;
            st_phase = '0;
            st_index = PCOUNT_W'(1);
        end
        else if (int'(st_index) + 1 >= cnt)
        begin
            trace_segment(st_prev, r, int'(st_index) - 1, 1'b0);
            trace_segment(r, st_first, int'(st_index), 1'b1);
            st_index = '0;
            st_prev  = r;
        end
        else
        begin
            trace_segment(st_prev, r, int'(st_index) - 1, 1'b0);
            st_prev  = r;
            st_index = st_index + 1'b1;
        end
    endfunction

    // Radii still needed to close the current outline at a given count
    function automatic int radii_to_close(int cnt_req);
        int cnt;
        cnt = (cnt_req > POINT_CAP) ? POINT_CAP : cnt_req;
        if (st_index == 0)
            return cnt;
        if (int'(st_index) + 1 >= cnt)
            return 1;
        return cnt - int'(st_index);
    endfunction

    // Mostly near unit radius, sometimes the extremes or anything
    function automatic logic [RADIUS_W-1:0] pick_radius();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        if (sel < 4)
            return RADIUS_W'($urandom);
        return RADIUS_W'($urandom_range(12288, 20480));
    endfunction

    // Gap length: quiet stretches with none, otherwise mostly short and a few long
    function automatic int idle_len(int long_max);
        int sel;
        if ((tick % 2048) < 400)
            return 0;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return 0;
        if (sel < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, long_max);
    endfunction

    task automatic flag_mismatch(input string detail);
        mismatch_count++;
        $display("%0t mismatch: %s", $time, detail);
    endtask

    task automatic feed_radius(input logic [RADIUS_W-1:0] r);
        radius_feed.push_back(r);
        radii_queued++;
    endtask

    task automatic feed_random(input int n);
        repeat (n) feed_radius(pick_radius());
    endtask

    // Wait until every radius is taken and every vertex has arrived, then settle
    task automatic wait_quiet(input int extra);
        do
            @(posedge clk);
        while (radii_taken != radii_queued || expected_vertices.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_POINT_COUNT: cfg_points = val[PCOUNT_W-1:0];
            CFG_PHASE_STEP:  cfg_step   = val[PHASE_W-1:0];
            CFG_ITEM_RADIUS: cfg_irad   = val[IRAD_W-1:0];
            default: ;
        endcase
    endtask

    // Radius driver: predict on acceptance, then offer the next item after a gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            radius   <= '0;
            feed_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                outline_advance(radius);
                radii_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (feed_gap != 0)
                begin
                    in_valid <= 1'b0;
                    feed_gap <= feed_gap - 1;
                end
                else if (radius_feed.size() != 0)
                begin
                    in_valid <= 1'b1;
                    radius   <= radius_feed.pop_front();
                    feed_gap <= idle_len(60);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Vertex sink: random back-pressure plus one long hold-off while radii are waiting
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_hold <= 0;
        end
        else if (!choke_done && vertices_seen >= CHOKE_AT && radius_feed.size() > 2)
        begin
            out_ready  <= 1'b0;
            sink_hold  <= CHOKE_CYCLES;
            choke_done <= 1'b1;
        end
        else if (sink_hold != 0)
        begin
            out_ready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            sink_hold <= idle_len(120);
        end
    end

    // Compare each accepted vertex against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            vertices_seen++;
            if (expected_vertices.size() == 0)
                flag_mismatch($sformatf("vertex with nothing expected: x=%0d y=%0d n=%0d done=%0b",
                              vertex_x, vertex_y, vertex_number, outline_done));
            else
            begin
                want_vertex = expected_vertices.pop_front();
                if (vertex_x !== want_vertex.x || vertex_y !== want_vertex.y ||
                    vertex_number !== want_vertex.num || outline_done !== want_vertex.done)
                    flag_mismatch({
                        $sformatf("vertex %0d: got x=%0d y=%0d n=%0d done=%0b",
                                  vertices_seen, vertex_x, vertex_y, vertex_number,
                                  outline_done),
                        $sformatf(", want x=%0d y=%0d n=%0d done=%0b",
                                  want_vertex.x, want_vertex.y, want_vertex.num,
                                  want_vertex.done)});
            end
        end
    end

    // Watchdog: end the run when no channel moves an item for too long
    initial
    begin
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            tick++;
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    // Stimulus: directed corners, then random outlines
    initial
    begin
        int kind;
        int cnt;
        int spread;
        int n;
        int budget;
        bit big_done;

        budget   = 0;
        big_done = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: smallest outline with radius extremes
        feed_radius('0);
        feed_radius('1);
        feed_radius(16'd16384);
        wait_quiet(SETTLE_CYCLES);

        // Largest item radius and step
        write_reg(CFG_POINT_COUNT, 16'd4);
        write_reg(CFG_PHASE_STEP, 16'hFFFF);
        write_reg(CFG_ITEM_RADIUS, 16'hFFFF);
        feed_radius('1);
        feed_radius('0);
        feed_radius('1);
        feed_radius(16'd32768);
        wait_quiet(SETTLE_CYCLES);

        // Zero item radius, unit step
        write_reg(CFG_POINT_COUNT, 16'd3);
        write_reg(CFG_PHASE_STEP, 16'd1);
        write_reg(CFG_ITEM_RADIUS, 16'd0);
        feed_radius(16'd12345);
        feed_radius(16'd54321);
        feed_radius(16'd1);
        wait_quiet(SETTLE_CYCLES);

        // Lower the count in the middle of an outline
        write_reg(CFG_POINT_COUNT, 16'd10);
        write_reg(CFG_PHASE_STEP, 16'd1638);
        write_reg(CFG_ITEM_RADIUS, 16'd160);
        feed_random(4);
        wait_quiet(SETTLE_CYCLES);
        write_reg(CFG_POINT_COUNT, 16'd3);
        feed_radius(pick_radius());
        wait_quiet(SETTLE_CYCLES);

        // Too few points: radii are dropped, upper data bits ignored
        write_reg(CFG_POINT_COUNT, 16'd0);
        feed_random(2);
        wait_quiet(SETTLE_CYCLES);
        write_reg(CFG_POINT_COUNT, 16'd2);
        feed_random(1);
        wait_quiet(SETTLE_CYCLES);
        write_reg(CFG_POINT_COUNT, 16'hFE01);
        feed_random(1);
        wait_quiet(SETTLE_CYCLES);
        write_reg(CFG_SPARE, 16'h5A5A);

        // Random outlines, mostly well formed
        while (budget < RANDOM_RADII)
        begin
            wait_quiet(SETTLE_CYCLES);
            kind = $urandom_range(0, 9);
            if (!big_done && budget >= RANDOM_RADII / 16)
            begin
                // Close the current outline at the point cap, count above it
                big_done = 1'b1;
                write_reg(CFG_POINT_COUNT, 16'd511);
                write_reg(CFG_PHASE_STEP, 16'd64);
                write_reg(CFG_ITEM_RADIUS, 16'($urandom_range(16, 1024)));
                n = radii_to_close(POINT_CAP);
            end
            else if (kind == 0)
            begin
                write_reg(CFG_POINT_COUNT,
                          {7'($urandom), 9'($urandom_range(0, MIN_POINTS - 1))});
                n = $urandom_range(1, 4);
            end
            else
            begin
                cnt = (kind == 1) ? $urandom_range(POINT_CAP + 1, 511)
                                  : $urandom_range(MIN_POINTS, 12);
                spread = $urandom_range(0, 7);
                write_reg(CFG_POINT_COUNT, 16'(cnt));
                write_reg(CFG_PHASE_STEP, ($urandom_range(0, 3) == 0) ? 16'($urandom)
                          : 16'(65536 / (4 * ((cnt > POINT_CAP) ? POINT_CAP : cnt))));
                write_reg(CFG_ITEM_RADIUS, (spread == 0) ? 16'd0 :
                          (spread == 1) ? 16'hFFFF : 16'($urandom_range(1, 4096)));
                n = radii_to_close(cnt);
                // Leave an outline open, break one short, or run one more whole
                if (kind == 1)
                    n = $urandom_range(1, 6);
                else if (kind == 2)
                    n = $urandom_range(1, n);
                else if (kind >= 8)
                    n = n + cnt;
            end
            feed_random(n);
            budget += n;
        end

        wait_quiet(SETTLE_CYCLES * 3);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
